>>> rtl/civil_date_to_epoch_seconds_defines.svh
// ---------------------------------------------------------------------------
// civil_date_to_epoch_seconds_defines
// Assertion macros shared by the date-to-epoch block.
// ---------------------------------------------------------------------------
`ifndef CIVIL_DATE_TO_EPOCH_SECONDS_DEFINES_SVH
`define CIVIL_DATE_TO_EPOCH_SECONDS_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CDES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdes same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CDES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdes next-cycle check failed");

`endif

>>> rtl/cdes_pkg.sv
// ---------------------------------------------------------------------------
// cdes_pkg
// Types, constants and tables for the date-to-epoch pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package cdes_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int EPOCH_W = 38;

    localparam int ERA_W  = 6;   // year / 400, year below 16384
    localparam int YOE_W  = 9;   // year of era, 0..399
    localparam int DOY_W  = 9;   // day of March-based year
    localparam int TOD_W  = 17;  // second of day, up to 86400
    localparam int DOE_W  = 18;  // day of era
    localparam int DAYS_W = 23;  // days since epoch

    localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1970;
    localparam logic [DAYS_W-1:0]  EPOCH_SHIFT = 23'd719468;
    localparam logic [DAYS_W-1:0]  ERA_DAYS    = 23'd146097;

    // one request as it enters
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_req;

    // after validation and year split
    typedef struct packed {
        logic              ok;
        logic [ERA_W-1:0]  era;
        logic [YOE_W-1:0]  yoe;
        logic [DOY_W-1:0]  doy;
        logic [TOD_W-1:0]  tod;
    } t_front;

    // after day count
    typedef struct packed {
        logic              ok;
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
    } t_days;

    // days in month, February as common year; invalid months give 0
    function automatic logic [DAY_W-1:0] f_month_days(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] d;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // days before month, year starting in March (mp = 0 is March)
    function automatic logic [DOY_W-1:0] f_march_days(input logic [MONTH_W-1:0] mp);
        logic [DOY_W-1:0] d;
        unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> rtl/civil_date_to_epoch_seconds.sv
// An accepted request passes through cdes_front, cdes_days and cdes_secs to the outputs.
// Throughput: one request per cycle; the six-stage pipeline has no loop.
// A stalled result freezes every stage, so the input stalls only while the
// output register holds a result that is not taken.
// Reset (i_rst_n low at a clock edge) clears all stage valid bits; the
// datapath registers are not reset.
// ---------------------------------------------------------------------------
// civil_date_to_epoch_seconds
// Converts a broken-down UTC date and time into Unix epoch seconds.
// ---------------------------------------------------------------------------
`default_nettype none

`include "civil_date_to_epoch_seconds_defines.svh"

module civil_date_to_epoch_seconds (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [cdes_pkg::YEAR_W-1:0]   i_year,
    input  wire logic [cdes_pkg::MONTH_W-1:0]  i_month,
    input  wire logic [cdes_pkg::DAY_W-1:0]    i_day,
    input  wire logic [cdes_pkg::HOUR_W-1:0]   i_hour,
    input  wire logic [cdes_pkg::MIN_W-1:0]    i_minute,
    input  wire logic [cdes_pkg::SEC_W-1:0]    i_second,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_valid_res,
    output logic [cdes_pkg::EPOCH_W-1:0]       o_epoch_seconds
);
    import cdes_pkg::*;

    t_req   req;
    t_front front;
    t_days  days;
    logic   front_vld;
    logic   days_vld;
    logic   en;

    // The pipeline moves as one: it freezes only when the output register
    // holds a result and the sink stalls. Bubbles may sit in any stage.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    assign req.year   = i_year;
    assign req.month  = i_month;
    assign req.day    = i_day;
    assign req.hour   = i_hour;
    assign req.minute = i_minute;
    assign req.second = i_second;

    // stages 1-2: field checks, leap year, era split, day of year, time of day
    cdes_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_req   (req),
        .o_vld   (front_vld),
        .o_front (front)
    );

    // stages 3-4: day of era and days since 1970-01-01
    cdes_days u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (front_vld),
        .i_front (front),
        .o_vld   (days_vld),
        .o_days  (days)
    );

    // stages 5-6: scale to seconds, add time of day, zero when invalid
    cdes_secs u_secs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (days_vld),
        .i_days  (days),
        .o_vld   (o_valid),
        .o_ok    (o_valid_res),
        .o_secs  (o_epoch_seconds)
    );

    // a rejected date always reports zero seconds
    `CDES_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n, o_valid && !o_valid_res, o_epoch_seconds == '0)
    // back-pressure on the input only comes from a held, stalled result
    `CDES_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    // a request accepted with the pipeline moving lands in stage 1
    `CDES_ASSERT_NEXT(a_enter, i_clk, i_rst_n, i_valid && !o_stall, u_front.r_s1_vld)

endmodule

`default_nettype wire

>>> rtl/cdes_front.sv
// ---------------------------------------------------------------------------
// cdes_front
// Stages 1-2: range checks, era split, leap year, day of year, time of day.
// ---------------------------------------------------------------------------
`default_nettype none

module cdes_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire cdes_pkg::t_req  i_req,
    output logic                 o_vld,
    output cdes_pkg::t_front     o_front
);
    import cdes_pkg::*;

    // stage 1 combinational
    logic [YEAR_W-1:0] n_y;
    logic [20:0]       era_prod;
    logic [24:0]       q_prod;
    logic              n_ok;
    logic [MONTH_W-1:0] n_mp;

    // stage 1 registers
    logic               r_s1_vld;
    logic               r_ok1;
    logic [YEAR_W-1:0]  r_y;
    logic [ERA_W-1:0]   r_era;
    logic [7:0]         r_q100;
    logic [11:0]        r_yq;
    logic               r_m4;
    logic               r_feb;
    logic [DAY_W-1:0]   r_limit;
    logic [MONTH_W-1:0] r_mp;
    logic [DAY_W-1:0]   r_day;
    logic [HOUR_W-1:0]  r_hour;
    logic [MIN_W-1:0]   r_min;
    logic [SEC_W-1:0]   r_sec;

    // stage 2 combinational
    logic [11:0]       mul25;
    logic              leap;
    logic [DAY_W:0]    lim;
    logic [YEAR_W-1:0] yoe_full;
    t_front            n_front;

    // stage 2 registers
    logic   r_s2_vld;
    t_front r_front;

    // March-based year; y/400 as (y>>4)/25 through 1311/2^15
    assign n_y      = i_req.year - {13'd0, (i_req.month <= 4'd2)};
    assign era_prod = {11'd0, n_y[13:4]} * 21'd1311;
    // year/100 as (year>>2)/25 through 5243/2^17
    assign q_prod   = {13'd0, i_req.year[13:2]} * 25'd5243;
    assign n_ok     = (i_req.year >= YEAR_MIN) && (i_req.month >= 4'd1) &&
                      (i_req.month <= 4'd12) && (i_req.day != 5'd0) &&
                      (i_req.hour <= 5'd23) && (i_req.minute <= 6'd59) &&
                      (i_req.second <= 6'd60);
    assign n_mp     = (i_req.month > 4'd2) ? (i_req.month - 4'd3) : (i_req.month + 4'd9);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok1   <= n_ok;
            r_y     <= n_y;
            r_era   <= era_prod[20:15];
            r_q100  <= q_prod[24:17];
            r_yq    <= i_req.year[13:2];
            r_m4    <= (i_req.year[1:0] == 2'b00);
            r_feb   <= (i_req.month == 4'd2);
            r_limit <= f_month_days(i_req.month);
            r_mp    <= n_mp;
            r_day   <= i_req.day;
            r_hour  <= i_req.hour;
            r_min   <= i_req.minute;
            r_sec   <= i_req.second;
        end
    end

    // leap: divisible by 4 and (not by 100, or year/100 divisible by 4)
    assign mul25    = {4'd0, r_q100} * 12'd25;
    assign leap     = r_m4 && ((r_yq != mul25) || (r_q100[1:0] == 2'b00));
    assign lim      = {1'b0, r_limit} + {5'd0, (r_feb && leap)};
    assign yoe_full = r_y - ({8'd0, r_era} * 14'd400);

    always_comb begin
        n_front.ok  = r_ok1 && ({1'b0, r_day} <= lim);
        n_front.era = r_era;
        n_front.yoe = yoe_full[YOE_W-1:0];
        n_front.doy = f_march_days(r_mp) + {4'd0, r_day} - 9'd1;
        n_front.tod = ({12'd0, r_hour} * 17'd3600) + ({11'd0, r_min} * 17'd60) +
                      {11'd0, r_sec};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (i_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_vld   = r_s2_vld;
    assign o_front = r_front;

endmodule

`default_nettype wire

>>> rtl/cdes_days.sv
// ---------------------------------------------------------------------------
// cdes_days
// Stages 3-4: day of era, era days, days since the epoch.
// ---------------------------------------------------------------------------
`default_nettype none

module cdes_days (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire cdes_pkg::t_front  i_front,
    output logic                   o_vld,
    output cdes_pkg::t_days        o_days
);
    import cdes_pkg::*;

    logic [1:0]        c100;
    logic [DOE_W-1:0]  n_doe;
    logic [DAYS_W-1:0] n_era_days;

    logic              r_s3_vld;
    logic              r_ok3;
    logic [DOE_W-1:0]  r_doe;
    logic [DAYS_W-1:0] r_era_days;
    logic [TOD_W-1:0]  r_tod3;

    logic   r_s4_vld;
    t_days  r_days;

    // yoe / 100 for yoe below 400
    always_comb begin
        priority if (i_front.yoe >= 9'd300) begin
            c100 = 2'd3;
        end else if (i_front.yoe >= 9'd200) begin
            c100 = 2'd2;
        end else if (i_front.yoe >= 9'd100) begin
            c100 = 2'd1;
        end else begin
            c100 = 2'd0;
        end
    end

    assign n_doe = ({9'd0, i_front.yoe} * 18'd365) + {11'd0, i_front.yoe[8:2]} +
                   {9'd0, i_front.doy} - {16'd0, c100};
    assign n_era_days = {17'd0, i_front.era} * ERA_DAYS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else if (i_en) begin
            r_s3_vld <= i_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok3       <= i_front.ok;
            r_doe       <= n_doe;
            r_era_days  <= n_era_days;
            r_tod3      <= i_front.tod;
            r_days.ok   <= r_ok3;
            r_days.days <= r_era_days + {5'd0, r_doe} - EPOCH_SHIFT;
            r_days.tod  <= r_tod3;
        end
    end

    assign o_vld  = r_s4_vld;
    assign o_days = r_days;

endmodule

`default_nettype wire

>>> rtl/cdes_secs.sv
// ---------------------------------------------------------------------------
// cdes_secs
// Stages 5-6: days times 86400, plus time of day, output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cdes_secs (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire cdes_pkg::t_days  i_days,
    output logic                  o_vld,
    output logic                  o_ok,
    output logic [cdes_pkg::EPOCH_W-1:0] o_secs
);
    import cdes_pkg::*;

    logic [39:0]        prod;

    logic               r_s5_vld;
    logic               r_ok5;
    logic [EPOCH_W-1:0] r_prod;
    logic [TOD_W-1:0]   r_tod5;

    logic               r_s6_vld;
    logic               r_ok6;
    logic [EPOCH_W-1:0] r_secs;

    assign prod = {17'd0, i_days.days} * 40'd86400;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else if (i_en) begin
            r_s5_vld <= i_vld;
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok5  <= i_days.ok;
            r_prod <= prod[EPOCH_W-1:0];
            r_tod5 <= i_days.tod;
            r_ok6  <= r_ok5;
            r_secs <= r_ok5 ? (r_prod + {21'd0, r_tod5}) : '0;
        end
    end

    assign o_vld  = r_s6_vld;
    assign o_ok   = r_ok6;
    assign o_secs = r_secs;

endmodule

`default_nettype wire
